>>> rtl/core/bple_pkg.sv
// Shared types and constants for the bounded point list engine.
// No dependencies; every module of the engine imports this package.
`timescale 1ns / 1ps

package bple_pkg;

  localparam int DEPTH      = 64;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int COORD_W    = 8;
  localparam int PT_W       = 2 * COORD_W;
  localparam int MODE_W     = 3;
  localparam int SIZE_W     = 7;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [COORD_W-1:0] INVALID_COORD = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SEARCH = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_REV    = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP,
    ST_SRCH,
    ST_SHIFT,
    ST_RV_I,
    ST_RV_J,
    ST_RV_W,
    ST_DONE
  } state_t;

  // One write port and one read port per cycle
  typedef struct packed {
    logic            we;
    logic [AW-1:0]   waddr;
    logic [PT_W-1:0] wdata;
    logic [AW-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [SIZE_W-1:0]  list_size;
  } result_t;

endpackage

>>> rtl/core/bple_ram.sv
// Point store: DEPTH x 16-bit synchronous RAM, one write and one read per cycle.
// Read data is registered and returns the old contents on a same-address write.
`timescale 1ns / 1ps

module bple_ram
  import bple_pkg::*;
(
  input  logic            clk,
  input  mem_req_t        req,
  output logic [PT_W-1:0] rdata
);

  logic [PT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> rtl/core/bple_ctrl.sv
// Operation sequencer: count register, search/shift/reverse walks over the store.
// Depends on bple_pkg; drives the bple_ram request and reads its data.
`timescale 1ns / 1ps

module bple_ctrl
  import bple_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  output mem_req_t           mem_req,
  input  logic [PT_W-1:0]    rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  state_t             state, state_next;
  logic [MODE_W-1:0]  mode, mode_next;
  logic [PT_W-1:0]    pt, pt_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      vidx, vidx_next;
  logic               vld, vld_next;
  logic [AW-1:0]      ri, ri_next;
  logic [AW-1:0]      rj, rj_next;
  logic               pend, pend_next;
  logic               ok, ok_next;
  logic [COORD_W-1:0] rx, rx_next;
  logic [COORD_W-1:0] ry, ry_next;
  logic [CW-1:0]      cnt_dec;
  logic [CW-1:0]      vidx_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      vld   <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      vld   <= vld_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    mode <= mode_next;
    pt   <= pt_next;
    idx  <= idx_next;
    vidx <= vidx_next;
    ri   <= ri_next;
    rj   <= rj_next;
    ok   <= ok_next;
    rx   <= rx_next;
    ry   <= ry_next;
  end

  assign cnt_dec  = count - CW'(1);
  assign vidx_dec = vidx - CW'(1);

  always_comb begin
    state_next = state;
    mode_next  = mode;
    pt_next    = pt;
    count_next = count;
    idx_next   = idx;
    vidx_next  = vidx;
    vld_next   = vld;
    ri_next    = ri;
    rj_next    = rj;
    pend_next  = pend;
    ok_next    = ok;
    rx_next    = rx;
    ry_next    = ry;
    mem_req    = '0;
    in_ready   = (state == ST_IDLE);
    res_valid  = (state == ST_DONE);
    res        = '{ok: ok, out_x: rx, out_y: ry, list_size: SIZE_W'(count)};

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mode_next  = in_mode;
          pt_next    = {in_x, in_y};
          state_next = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        ok_next    = 1'b0;
        rx_next    = '0;
        ry_next    = '0;
        state_next = ST_DONE;
        unique case (mode)
          OP_PUSH: begin
            if (count < CW'(DEPTH) && pt[PT_W-1:COORD_W] != INVALID_COORD &&
                pt[COORD_W-1:0] != INVALID_COORD) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count[AW-1:0];
              mem_req.wdata = pt;
              count_next    = count + CW'(1);
              ok_next       = 1'b1;
            end
          end
          OP_POP: begin
            if (count != '0) begin
              mem_req.raddr = cnt_dec[AW-1:0];
              state_next    = ST_POP;
            end
          end
          OP_SEARCH, OP_REMOVE: begin
            idx_next   = '0;
            vld_next   = 1'b0;
            state_next = ST_SRCH;
          end
          OP_CLEAR: begin
            count_next = '0;
            ok_next    = 1'b1;
          end
          OP_REV: begin
            ok_next = 1'b1;
            if (count > CW'(1)) begin
              ri_next    = '0;
              rj_next    = cnt_dec[AW-1:0];
              pend_next  = 1'b0;
              state_next = ST_RV_I;
            end
          end
          default: ;
        endcase
      end

      ST_POP: begin
        count_next = cnt_dec;
        ok_next    = 1'b1;
        rx_next    = rdata[PT_W-1:COORD_W];
        ry_next    = rdata[COORD_W-1:0];
        state_next = ST_DONE;
      end

      // Issue one read per cycle, compare the returning entry on the next cycle
      ST_SRCH: begin
        if (vld && rdata == pt) begin
          if (mode == OP_REMOVE) begin
            idx_next   = vidx + CW'(1);
            vld_next   = 1'b0;
            state_next = ST_SHIFT;
          end else begin
            ok_next    = 1'b1;
            state_next = ST_DONE;
          end
        end else if (idx < count) begin
          mem_req.raddr = idx[AW-1:0];
          idx_next      = idx + CW'(1);
          vld_next      = 1'b1;
          vidx_next     = idx;
        end else begin
          vld_next   = 1'b0;
          ok_next    = 1'b0;
          state_next = ST_DONE;
        end
      end

      // Read entry k, write it back at k-1 on the next cycle
      ST_SHIFT: begin
        if (vld) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = vidx_dec[AW-1:0];
          mem_req.wdata = rdata;
        end
        if (idx < count) begin
          mem_req.raddr = idx[AW-1:0];
          idx_next      = idx + CW'(1);
          vld_next      = 1'b1;
          vidx_next     = idx;
        end else begin
          vld_next = 1'b0;
          if (!vld) begin
            count_next = cnt_dec;
            ok_next    = 1'b1;
            state_next = ST_DONE;
          end
        end
      end

      // Read low slot; finish the previous pair by writing its low slot
      ST_RV_I: begin
        mem_req.raddr = ri;
        if (pend) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ri - AW'(1);
          mem_req.wdata = rdata;
        end
        state_next = ST_RV_J;
      end

      // Read the high slot and overwrite it with the low entry (read-first)
      ST_RV_J: begin
        mem_req.raddr = rj;
        mem_req.we    = 1'b1;
        mem_req.waddr = rj;
        mem_req.wdata = rdata;
        ri_next       = ri + AW'(1);
        rj_next       = rj - AW'(1);
        pend_next     = 1'b1;
        if ((ri + AW'(1)) < (rj - AW'(1))) begin
          state_next = ST_RV_I;
        end else begin
          state_next = ST_RV_W;
        end
      end

      ST_RV_W: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ri - AW'(1);
        mem_req.wdata = rdata;
        pend_next     = 1'b0;
        state_next    = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_req.we)
    else $error("store written while idle");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result dropped before hand-off");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT && mem_req.we |-> CW'(mem_req.waddr) < count)
    else $error("shift write beyond held points");
`endif

endmodule

>>> rtl/core/bounded_point_list_engine_core.sv
// Bounded point list engine: top level with stream ports and output register.
// Depends on bple_pkg, bple_ram and bple_ctrl.
// Push, clear and unused modes finish at dispatch; pop reads the top entry, search
// and remove walk the stored points, remove then shifts the later points down, and
// reverse swaps pairs from both ends. One item is in work at a time; the next input is taken
// once the sequencer has handed its result to the output register, the single
// store port pair (one read, one write per cycle) setting the walk length.
// Reset (rst, synchronous) empties the list and the output; the store is not cleared.
`timescale 1ns / 1ps

module bounded_point_list_engine_core
  import bple_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata: mode[2:0], pt_x[10:3], pt_y[18:11], zero pad[23:19]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata: ok[0], out_x[8:1], out_y[16:9], list_size[23:17]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  mem_req_t        mem_req;
  logic [PT_W-1:0] rdata;
  logic            res_valid;
  logic            res_ready;
  result_t         res;

  // Unpack the input transfer
  logic [MODE_W-1:0]  in_mode;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;

  assign in_mode = s_tdata[MODE_W-1:0];
  assign in_x    = s_tdata[MODE_W +: COORD_W];
  assign in_y    = s_tdata[MODE_W + COORD_W +: COORD_W];

  bple_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  bple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (in_mode),
    .in_x      (in_x),
    .in_y      (in_y),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: take a new result when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Pack the result: ok lowest, then x, y, list size
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res.list_size, res.out_y, res.out_x, res.ok};
    end
  end

endmodule

>>> tb/sv/bple_checker.sv
// Scoreboard for the bounded point list engine: watches both stream channels,
// keeps its own copy of the point list and compares every result it sees.
// Depends on bple_pkg for sizes, operation codes and the result layout.
`timescale 1ns / 1ps

module bple_checker
  import bple_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     pending,
  output int                     op_total,
  output int                     peak_size,
  output int                     hit_total
);

  logic [PT_W-1:0] held_points [DEPTH];
  int unsigned     held_count;
  result_t         pending_results [$];
  result_t         oldest;

  // Apply one operation to the local list and return the result it must give.
  function automatic result_t predict_list_op(input logic [MODE_W-1:0]  md,
                                              input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
    result_t         r;
    logic [PT_W-1:0] p;
    logic [PT_W-1:0] t;
    int              idx;
    int              i;
    r   = '0;
    p   = {x, y};
    idx = -1;
    case (md)
      OP_PUSH: begin
        if (held_count < DEPTH && x != INVALID_COORD && y != INVALID_COORD) begin
          held_points[held_count] = p;
          held_count++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (held_count > 0) begin
          held_count--;
          {r.out_x, r.out_y} = held_points[held_count];
          r.ok = 1'b1;
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        for (i = 0; i < held_count; i++)
          if (idx < 0 && held_points[i] == p) idx = i;
        if (idx >= 0) begin
          r.ok = 1'b1;
          hit_total++;
          if (md == OP_REMOVE) begin
            // close the gap: later points slide down one slot
            for (i = idx; i + 1 < held_count; i++)
              held_points[i] = held_points[i + 1];
            held_count--;
          end
        end
      end
      OP_CLEAR: begin
        held_count = 0;
        r.ok = 1'b1;
      end
      OP_REV: begin
        for (i = 0; i < held_count / 2; i++) begin
          t = held_points[i];
          held_points[i] = held_points[held_count - 1 - i];
          held_points[held_count - 1 - i] = t;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.list_size = SIZE_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, expected none, got tdata %h",
                   $time, m_tdata);
        end else begin
          oldest = pending_results.pop_front();
          check_field("ok",        int'(oldest.ok),        int'(m_tdata[0]));
          check_field("out_x",     int'(oldest.out_x),     int'(m_tdata[8:1]));
          check_field("out_y",     int'(oldest.out_y),     int'(m_tdata[16:9]));
          check_field("list_size", int'(oldest.list_size), int'(m_tdata[23:17]));
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_list_op(s_tdata[2:0], s_tdata[10:3],
                                                  s_tdata[18:11]));
        op_total++;
        if (held_count > peak_size) peak_size = held_count;
      end
    end
    pending = pending_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the point list engine testbench: clock, reset, stimulus and verdict.
// Depends on bple_pkg, bple_checker and the bounded_point_list_engine_core RTL.
`timescale 1ns / 1ps

module testbench;
  import bple_pkg::*;

  // Mode codes the engine leaves unused; they must change nothing
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  // Longest run of cycles with no transfer on either side before giving up;
  // a slow reverse, a long receiver stall and a long sender gap stay far below
  localparam int IDLE_LIMIT = 2000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int op_total;
  int peak_size;
  int hit_total;

  // Sender bookkeeping: valid_hi mirrors s_tvalid without waiting on the NBA
  bit valid_hi = 1'b0;
  int burst_left = 4;
  int rx_cycle = 0;
  int stall_run = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_point_list_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bple_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .op_total   (op_total),
    .peak_size  (peak_size),
    .hit_total  (hit_total)
  );

  // Receiver: rotate through four stall styles so that
  // back-pressure lands on every phase of the engine's work.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 150) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      2: begin
        // long runs: hold the current level, then flip it
        if (stall_run == 0) begin
          m_tready  <= ~m_tready;
          stall_run <= $urandom_range(1, 25);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
      default: m_tready <= (rx_cycle % 3 == 0);
    endcase
  end

  // Watchdog: any transfer restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one operation from a falling edge and hold it until the transfer.
  // When a burst runs out, drop valid and idle for a random gap.
  task automatic send_op(input logic [MODE_W-1:0]  md,
                         input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, y, x, md};
    valid_hi = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      valid_hi = 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 40)) @(negedge clk);
      else repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    if (valid_hi) begin
      s_tvalid <= 1'b0;
      valid_hi = 1'b0;
    end
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Coordinates: half from a tiny pool so searches and removes hit, some full
  // range, and a share of the invalid marker.
  function automatic logic [COORD_W-1:0] pick_coord(input int bad_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < bad_pct) return INVALID_COORD;
    if (r < bad_pct + 50) return COORD_W'($urandom_range(0, 3));
    return COORD_W'($urandom_range(0, 254));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int w_push, input int w_pop,
                                                  input int w_srch, input int w_rem,
                                                  input int w_rev, input int w_clr,
                                                  input int w_spare);
    int r;
    r = $urandom_range(0, w_push + w_pop + w_srch + w_rem + w_rev + w_clr + w_spare - 1);
    if (r < w_push) return OP_PUSH;
    r -= w_push;
    if (r < w_pop) return OP_POP;
    r -= w_pop;
    if (r < w_srch) return OP_SEARCH;
    r -= w_srch;
    if (r < w_rem) return OP_REMOVE;
    r -= w_rem;
    if (r < w_rev) return OP_REV;
    r -= w_rev;
    if (r < w_clr) return OP_CLEAR;
    return $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
  endfunction

  task automatic random_ops(input int n, input int w_push, input int w_pop,
                            input int w_srch, input int w_rem, input int w_rev,
                            input int w_clr, input int w_spare, input int bad_pct);
    repeat (n)
      send_op(pick_mode(w_push, w_pop, w_srch, w_rem, w_rev, w_clr, w_spare),
              pick_coord(bad_pct), pick_coord(bad_pct));
  endtask

  initial begin
    // Hold reset, then release it on a falling edge
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, invalid marker, duplicates, every mode
    send_op(OP_PUSH,   8'd0,   8'd0);
    send_op(OP_PUSH,   8'd254, 8'd254);
    send_op(OP_PUSH,   8'd255, 8'd0);     // invalid x: reject
    send_op(OP_PUSH,   8'd0,   8'd255);   // invalid y: reject
    send_op(OP_PUSH,   8'd255, 8'd255);
    send_op(OP_PUSH,   8'd1,   8'd2);
    send_op(OP_PUSH,   8'd0,   8'd0);     // duplicate of the first point
    send_op(OP_SEARCH, 8'd254, 8'd254);
    send_op(OP_SEARCH, 8'd3,   8'd3);
    send_op(OP_SEARCH, 8'd255, 8'd255);   // invalid point is never found
    send_op(OP_REMOVE, 8'd0,   8'd0);     // first copy goes, rest shift down
    send_op(OP_REV,    8'd0,   8'd0);
    send_op(OP_POP,    8'd77,  8'd88);
    send_op(OP_REMOVE, 8'd9,   8'd9);
    send_op(OP_REMOVE, 8'd0,   8'd255);
    send_op(OP_POP,    8'd0,   8'd0);
    send_op(OP_POP,    8'd0,   8'd0);
    send_op(OP_POP,    8'd255, 8'd255);   // pop on an empty list
    send_op(OP_REV,    8'd0,   8'd0);     // reverse of nothing
    send_op(OP_PUSH,   8'd5,   8'd6);
    send_op(OP_REV,    8'd0,   8'd0);     // reverse of a single point
    send_op(MODE_SPARE_A, 8'd1,   8'd1);
    send_op(MODE_SPARE_B, 8'd255, 8'd255);
    send_op(OP_CLEAR,  8'd0,   8'd0);

    // Fill well past capacity so pushes on a full list get rejected
    random_ops(80, 1, 0, 0, 0, 0, 0, 0, 5);
    // Work on the full list: long searches, removes and reversals
    random_ops(40, 2, 1, 4, 4, 3, 0, 0, 5);

    // Let every outstanding result come back before going on
    drain_results();

    // Mixed traffic; pushes outweigh removals so the size wanders up and down
    random_ops(380, 35, 15, 15, 15, 8, 2, 2, 10);
    // Empty the list, then pop on empty
    random_ops(70, 0, 4, 1, 2, 1, 0, 0, 5);

    drain_results();
    repeat (DEPTH + 10) @(negedge clk);

    $display("Checked %0d operations; list peaked at %0d points, %0d searches/removes hit",
             op_total, peak_size, hit_total);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bple_pkg.sv
rtl/core/bple_ram.sv
rtl/core/bple_ctrl.sv
rtl/core/bounded_point_list_engine_core.sv
tb/sv/bple_checker.sv
tb/sv/testbench.sv
